>>> rtl/core/abt_pkg.sv
// Shared types for the array binary tree query unit: request and status
// codes and the result record handed from the engine to the top level.
// No dependencies.
package abt_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FOUND = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 7;
    localparam int LEVEL_W = 3;
    localparam int ORDER_W = 7;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   node_index;
        logic [LEVEL_W-1:0]   node_level;
        logic [ORDER_W-1:0]   level_order;
        logic                 has_parent;
        logic [CHAR_W-1:0]    parent_char;
        logic                 has_left;
        logic [CHAR_W-1:0]    left_char;
        logic                 has_right;
        logic [CHAR_W-1:0]    right_char;
    } result_t;

endpackage

>>> rtl/core/array_binary_tree_query_unit.sv
// Array binary tree query unit: level-order node table with append, clear
// and first-match query reporting position, level and neighbouring bytes.
// Append, clear and unused codes go from accept straight to S_EMIT.
// Query: one node memory read per cycle during the scan up to the hit,
// then parent, left and right reads; a miss scans to the last node.
// One item at a time; s_tready rises again as the result enters the output
// register. Synchronous active-low reset empties the table; no clearing pass.
module array_binary_tree_query_unit import abt_pkg::*; #(
    parameter int MAX_NODES = 127
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // node_char[7:0]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // node_index[6:0], node_level[9:7], level_order[16:10], has_parent[17],
    // parent_char[25:18], has_left[26], left_char[34:27], has_right[35],
    // right_char[43:36], zero[47:44]
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(MAX_NODES + 1);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;
    result_t           out_res;

    abt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_NODES + 1)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    abt_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_char   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {4'b0000,
                      out_res.right_char, out_res.has_right,
                      out_res.left_char,  out_res.has_left,
                      out_res.parent_char, out_res.has_parent,
                      out_res.level_order, out_res.node_level, out_res.node_index};

    // node memory is written only by an accepted append
    a_write_on_append: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (s_tvalid && s_tready && s_tuser == REQ_APPEND))
        else $error("node memory written outside an append beat");

    // one item at a time: not ready again in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous item still in flight");

    // a hit always names a position and level
    a_hit_has_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_FOUND) |-> (m_tdata[6:0] != 7'd0 || MAX_NODES > 127))
        else $error("query hit reported without a position");

    // anything but a hit carries an all-zero payload
    a_zero_on_other: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_FOUND) |-> (m_tdata == 48'd0))
        else $error("non-hit beat carries payload");

endmodule

>>> rtl/core/abt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module abt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/abt_engine.sv
// Request sequencer for the array binary tree query unit: appends, clears,
// scans the node memory and fetches parent and children, then holds the
// result in the output register. Depends on abt_pkg.
module abt_engine import abt_pkg::*; #(
    parameter int MAX_NODES = 127,
    localparam int AW       = $clog2(MAX_NODES + 1),
    localparam int LW       = $clog2(AW + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_req,
    input  logic [CHAR_W-1:0] in_char,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [CHAR_W-1:0] ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  logic [CHAR_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PARENT,
        S_LEFT,
        S_RIGHT,
        S_EMIT
    } state_t;

    state_t             state_reg,   state_next;
    logic [AW-1:0]      count_reg,   count_next;
    logic [AW-1:0]      ptr_reg,     ptr_next;
    logic [CHAR_W-1:0]  key_reg,     key_next;
    result_t            res_reg,     res_next;
    logic               ovalid_reg,  ovalid_next;
    result_t            ores_reg,    ores_next;

    logic [LW-1:0]      hit_level;
    logic [AW-1:0]      level_base;
    logic [AW-1:0]      hit_order;
    logic [AW:0]        twice_ptr;
    logic               left_there;
    logic               right_there;
    logic               accept;

    // level = position of the leading one, plus one
    always_comb begin
        hit_level = '0;
        for (int b = 0; b < AW; b++) begin
            if (ptr_reg[b]) begin
                hit_level = LW'(b + 1);
            end
        end
    end

    assign level_base  = (hit_level == '0) ? '0 : (AW'(1) << (hit_level - LW'(1)));
    assign hit_order   = ptr_reg - level_base + AW'(1);
    assign twice_ptr   = {ptr_reg, 1'b0};
    assign left_there  = twice_ptr <= {1'b0, count_reg};
    assign right_there = twice_ptr <  {1'b0, count_reg};

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        key_next    = key_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        ores_next   = ores_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg + AW'(1);
        ram_wdata   = in_char;
        ram_raddr   = '0;

        if (out_valid && out_ready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next   = in_char;
                    res_next   = '0;
                    state_next = S_EMIT;
                    unique case (in_req)
                        REQ_APPEND: begin
                            if (count_reg == AW'(MAX_NODES)) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + AW'(1);
                            end
                        end
                        REQ_QUERY: begin
                            if (count_reg == '0) begin
                                res_next.status = STAT_MISS;
                            end else begin
                                ptr_next   = AW'(1);
                                ram_raddr  = AW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read data belongs to ptr_reg; the next address goes out meanwhile
                if (ram_rdata == key_reg) begin
                    res_next.status      = STAT_FOUND;
                    res_next.node_index  = INDEX_W'(ptr_reg);
                    res_next.node_level  = LEVEL_W'(hit_level);
                    res_next.level_order = ORDER_W'(hit_order);
                    res_next.has_parent  = (ptr_reg != AW'(1));
                    res_next.has_left    = left_there;
                    res_next.has_right   = right_there;
                    ram_raddr            = ptr_reg >> 1;
                    state_next           = S_PARENT;
                end else if (ptr_reg == count_reg) begin
                    res_next.status = STAT_MISS;
                    state_next      = S_EMIT;
                end else begin
                    ptr_next  = ptr_reg + AW'(1);
                    ram_raddr = ptr_reg + AW'(1);
                end
            end
            S_PARENT: begin
                res_next.parent_char = res_reg.has_parent ? ram_rdata : '0;
                ram_raddr            = left_there ? AW'(twice_ptr) : '0;
                state_next           = S_LEFT;
            end
            S_LEFT: begin
                res_next.left_char = res_reg.has_left ? ram_rdata : '0;
                ram_raddr          = right_there ? AW'(twice_ptr + (AW+1)'(1)) : '0;
                state_next         = S_RIGHT;
            end
            S_RIGHT: begin
                res_next.right_char = res_reg.has_right ? ram_rdata : '0;
                state_next          = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!out_valid || out_ready) begin
                    ovalid_next = 1'b1;
                    ores_next   = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
        ptr_reg  <= ptr_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
        ores_reg <= ores_next;
    end

    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;

endmodule

>>> sim/array_binary_tree_query_unit_test.sv
// Testbench for array_binary_tree_query_unit: appends, clears, queries and unused
// request codes go in as stream beats, and each result beat is checked against a
// level-order tree predictor kept here. Depends on abt_pkg and the unit itself.
`timescale 1ns / 100ps

module array_binary_tree_query_unit_test import abt_pkg::*;;

    localparam int          TREE_CAP    = 127;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // node_char[7:0]
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    // node_index[6:0], node_level[9:7], level_order[16:10], has_parent[17],
    // parent_char[25:18], has_left[26], left_char[34:27], has_right[35],
    // right_char[43:36], zero[47:44]
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;   // status[1:0]

    // predictor state
    logic [7:0]  tree_bytes [1:TREE_CAP];
    int          tree_size;
    result_t     expected_answers [$];

    int          error_count;
    int          cycle_count;
    bit          idle_on;
    bit          hold_token;
    bit          hold_seen;
    int          rx_wait;

    array_binary_tree_query_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones; none while idling is switched off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // Work out the answer to one request and advance the tree copy.
    function automatic result_t predict_answer(input logic [1:0] req, input logic [7:0] ch);
        result_t ans;
        int      hit;
        int      lvl;
        ans = '0;
        ans.status = STAT_OK;
        case (req)
            REQ_APPEND: begin
                if (tree_size >= TREE_CAP) begin
                    ans.status = STAT_FULL;
                end else begin
                    tree_size++;
                    tree_bytes[tree_size] = ch;
                end
            end
            REQ_CLEAR: begin
                tree_size = 0;
            end
            REQ_QUERY: begin
                hit = 0;
                for (int i = 1; i <= tree_size; i++)
                    if (hit == 0 && tree_bytes[i] == ch)
                        hit = i;
                if (hit == 0) begin
                    ans.status = STAT_MISS;
                end else begin
                    lvl = $clog2(hit + 1);
                    ans.status      = STAT_FOUND;
                    ans.node_index  = hit[INDEX_W-1:0];
                    ans.node_level  = lvl[LEVEL_W-1:0];
                    ans.level_order = ORDER_W'(hit - (1 << (lvl - 1)) + 1);
                    if (hit > 1) begin
                        ans.has_parent  = 1'b1;
                        ans.parent_char = tree_bytes[hit / 2];
                    end
                    if (2 * hit <= tree_size) begin
                        ans.has_left  = 1'b1;
                        ans.left_char = tree_bytes[2 * hit];
                    end
                    if (2 * hit + 1 <= tree_size) begin
                        ans.has_right  = 1'b1;
                        ans.right_char = tree_bytes[2 * hit + 1];
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    task automatic check_answer();
        result_t got;
        result_t exp_a;
        got.status      = status_t'(m_tuser);
        got.node_index  = m_tdata[6:0];
        got.node_level  = m_tdata[9:7];
        got.level_order = m_tdata[16:10];
        got.has_parent  = m_tdata[17];
        got.parent_char = m_tdata[25:18];
        got.has_left    = m_tdata[26];
        got.left_char   = m_tdata[34:27];
        got.has_right   = m_tdata[35];
        got.right_char  = m_tdata[43:36];
        if (expected_answers.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual status %0d tdata %h",
                     $time, m_tuser, m_tdata);
            error_count++;
            return;
        end
        exp_a = expected_answers.pop_front();
        compare_field("status",      exp_a.status,      got.status);
        compare_field("node_index",  exp_a.node_index,  got.node_index);
        compare_field("node_level",  exp_a.node_level,  got.node_level);
        compare_field("level_order", exp_a.level_order, got.level_order);
        compare_field("has_parent",  exp_a.has_parent,  got.has_parent);
        compare_field("parent_char", exp_a.parent_char, got.parent_char);
        compare_field("has_left",    exp_a.has_left,    got.has_left);
        compare_field("left_char",   exp_a.left_char,   got.left_char);
        compare_field("has_right",   exp_a.has_right,   got.has_right);
        compare_field("right_char",  exp_a.right_char,  got.right_char);
    endtask

    // Result side: check each beat, then decide m_tready for the next edge.
    always @(posedge aclk) begin : result_side
        int g;
        if (aresetn && m_tvalid && m_tready)
            check_answer();
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            rx_wait   <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            g = pick_gap();
            if (g > 0) begin
                rx_wait  <= g - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request beat and hold it until accepted.
    task automatic send_request(input logic [1:0] req, input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        expected_answers.push_back(predict_answer(req, ch));
    endtask

    task automatic wait_all_answered(input int margin);
        s_tvalid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge aclk);
        repeat (margin) @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        send_request(REQ_QUERY,  8'h00);   // empty table
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_APPEND, 8'h00);
        send_request(REQ_APPEND, 8'hFF);
        send_request(REQ_APPEND, 8'h55);
        send_request(REQ_APPEND, 8'hAA);
        send_request(REQ_APPEND, 8'h23);   // the old '#' sentinel is an ordinary byte
        send_request(REQ_APPEND, 8'h80);
        send_request(REQ_QUERY,  8'hFF);
        send_request(REQ_QUERY,  8'h00);   // root: no parent
        send_request(REQ_QUERY,  8'h55);   // left child only
        send_request(REQ_QUERY,  8'h80);   // leaf
        send_request(REQ_QUERY,  8'h23);
        send_request(REQ_QUERY,  8'h01);   // miss
        send_request(REQ_APPEND, 8'hFF);   // duplicate
        send_request(REQ_QUERY,  8'h55);   // both children now
        send_request(REQ_QUERY,  8'hFF);   // first match wins
        send_request(REQ_CLEAR,  8'hA5);
        send_request(REQ_QUERY,  8'hFF);
        send_request(REQ_UNUSED, 8'h00);
        send_request(REQ_APPEND, 8'h7F);
        send_request(REQ_QUERY,  8'h7F);
    endtask

    // Fill with distinct bytes, overflow, then probe shallow and deep positions.
    task automatic test_fill_and_overflow();
        int base;
        int step;
        int probe [8] = '{127, 64, 63, 1, 2, 65, 100, 96};
        base = $urandom_range(0, 255);
        step = 2 * $urandom_range(0, 127) + 1;
        send_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
        for (int i = 1; i <= TREE_CAP; i++)
            send_request(REQ_APPEND, 8'(base + i * step));
        repeat (3) send_request(REQ_APPEND, 8'($urandom_range(0, 255)));
        foreach (probe[k])
            send_request(REQ_QUERY, tree_bytes[probe[k]]);
    endtask

    // Stall the result side for a long stretch while requests keep coming.
    task automatic test_receiver_hold_off();
        hold_token <= ~hold_token;
        for (int i = 0; i < 12; i++) begin
            if (tree_size > 0 && i % 2 == 1)
                send_request(REQ_QUERY, tree_bytes[$urandom_range(1, tree_size)]);
            else
                send_request(REQ_APPEND, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < 80; i++) begin
            if (i < 30 || $urandom_range(0, 2) == 0)
                send_request(REQ_APPEND, 8'($urandom_range(0, 31)));
            else
                send_request(REQ_QUERY, 8'($urandom_range(0, 31)));
        end
        idle_on = 1'b1;
    endtask

    // Usually clear, then build a tree and query it: most queries aim at stored bytes.
    task automatic test_random_episodes(input int budget);
        int         sent;
        int         n;
        int         alph;
        int         kind;
        logic [7:0] ch;
        sent = 0;
        while (sent < budget) begin
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) != 0) begin
                send_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
                sent++;
            end
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 135) : $urandom_range(0, 20);
            alph = ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(1, 15);
            repeat (n) begin
                send_request(REQ_APPEND, 8'($urandom_range(0, alph)));
                sent++;
            end
            repeat ($urandom_range(1, 15)) begin
                kind = $urandom_range(0, 99);
                if (kind < 60 && tree_size > 0)
                    ch = tree_bytes[$urandom_range(1, tree_size)];
                else if (kind < 80)
                    ch = 8'($urandom_range(0, alph));
                else
                    ch = 8'($urandom_range(0, 255));
                if (kind >= 95)
                    send_request(REQ_UNUSED, ch);
                else if (kind >= 88)
                    send_request(REQ_APPEND, ch);
                else
                    send_request(REQ_QUERY, ch);
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        tree_size   = 0;
        error_count = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        hold_token  = 1'b0;
        hold_seen   = 1'b0;
        rx_wait     = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        wait_all_answered(4);
        test_fill_and_overflow();
        test_receiver_hold_off();
        wait_all_answered(4);
        test_steady_stream();
        test_random_episodes(640);
        wait_all_answered(200);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
